### hdl/upd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_pkg: shared types and helpers for the URL percent decoder
// Beat payloads, the decode job passed from front to back, and the
// character classification functions.
// ----------------------------------------------------------------------------
package upd_pkg;

  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_run_last;
    logic       out_string_end;
  } out_item_t;

  // One decoded input: up to three bytes, emitted from slot 0 upward.
  typedef struct packed {
    logic [2:0][7:0] data;
    logic [1:0]      count;
    logic            str_end;
  } job_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'd48 && c <= 8'd57) || (c >= 8'd97 && c <= 8'd102) ||
           (c >= 8'd65 && c <= 8'd70);
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'd48 && c <= 8'd57) begin
      v = c - 8'd48;
    end else if (c >= 8'd97 && c <= 8'd102) begin
      v = c - 8'd87;
    end else if (c >= 8'd65 && c <= 8'd70) begin
      v = c - 8'd55;
    end else begin
      v = 8'd0;
    end
    return v[3:0];
  endfunction

  function automatic logic is_allowed(input logic [7:0] h);
    return (h >= 8'd48 && h <= 8'd57) || (h >= 8'd97 && h <= 8'd122) ||
           (h >= 8'd65 && h <= 8'd90) || h == 8'h21 || h == 8'h24 ||
           (h >= 8'h26 && h <= 8'h2B) || h == 8'h2D || h == 8'h2E ||
           h == 8'h3B || h == 8'h3F || h == 8'h40 || h == 8'h5F;
  endfunction

endpackage

### hdl/upd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_front: input classification
// Tracks the pending '%' and hex digit and turns each accepted byte into a
// job of zero to three output bytes.
// ----------------------------------------------------------------------------
module upd_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  upd_pkg::in_item_t item,
  output logic            job_valid,
  output upd_pkg::job_t   job
);
  import upd_pkg::*;

  logic [1:0] pend_count;
  logic [1:0] pend_count_next;
  logic [7:0] pend_digit;
  logic [7:0] pend_digit_next;

  logic       b_hex;
  logic [7:0] decoded;
  logic [1:0] pre;
  logic       do_plain;
  logic       plain_emit;
  logic [7:0] plain_byte;

  assign b_hex   = is_hex(item.in_byte);
  assign decoded = {hex_nibble(pend_digit), hex_nibble(item.in_byte)};

  always_comb begin
    pend_count_next = 2'd0;
    pend_digit_next = 8'd0;
    pre             = 2'd0;
    do_plain        = 1'b0;
    plain_emit      = 1'b0;
    plain_byte      = item.in_byte;
    job             = '0;
    job.str_end     = item.in_end;

    unique case (pend_count)
      2'd1: begin
        if (b_hex && !item.in_end) begin
          pend_count_next = 2'd2;
          pend_digit_next = item.in_byte;
        end else begin
          pre      = 2'd1;
          do_plain = 1'b1;
        end
      end
      2'd2: begin
        if (b_hex) begin
          if (is_allowed(decoded)) begin
            job.data[0] = decoded;
            job.count   = 2'd1;
          end else begin
            job.data[0] = CH_PERCENT;
            job.data[1] = pend_digit;
            job.data[2] = item.in_byte;
            job.count   = 2'd3;
          end
        end else begin
          pre      = 2'd2;
          do_plain = 1'b1;
        end
      end
      default: begin
        do_plain = 1'b1;
      end
    endcase

    if (do_plain) begin
      priority if (item.in_byte == CH_PLUS) begin
        plain_emit = 1'b1;
        plain_byte = CH_SPACE;
      end else if (item.in_byte == CH_PERCENT) begin
        if (item.in_end) begin
          plain_emit = 1'b1;
        end else begin
          pend_count_next = 2'd1;
        end
      end else begin
        plain_emit = 1'b1;
      end
      job.data[0] = CH_PERCENT;
      job.data[1] = pend_digit;
      job.data[pre] = plain_byte;
      job.count   = pre + {1'b0, plain_emit};
    end

    // The end of the string flushes everything that is pending.
    if (item.in_end) begin
      pend_count_next = 2'd0;
      pend_digit_next = 8'd0;
    end
  end

  assign job_valid = accept && (job.count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_count <= 2'd0;
      pend_digit <= 8'd0;
    end else if (accept) begin
      pend_count <= pend_count_next;
      pend_digit <= pend_digit_next;
    end
  end

endmodule

### hdl/upd_job_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_job_fifo: job queue between front and back
// A small register queue of decode jobs with a first-word view of its head.
// ----------------------------------------------------------------------------
module upd_job_fifo #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  upd_pkg::job_t wr_job,
  input  logic          rd_en,
  output upd_pkg::job_t head,
  output logic          full,
  output logic          empty
);
  import upd_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          store [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] fill;

  assign full  = (fill == CW'(DEPTH));
  assign empty = (fill == '0);
  assign head  = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        fill <= fill + 1'b1;
      end else if (rd_en && !wr_en) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

### hdl/upd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_back: result serializer
// Walks the bytes of the head job and loads them one at a time into the
// output register.
// ----------------------------------------------------------------------------
module upd_back (
  input  logic                 clk,
  input  logic                 rst,
  input  upd_pkg::job_t        head,
  input  logic                 head_empty,
  output logic                 head_done,
  input  logic                 pop,
  output logic                 empty,
  output upd_pkg::out_item_t   result
);
  import upd_pkg::*;

  logic       out_valid;
  logic [1:0] slot;
  logic       load;
  logic       run_last;

  assign load      = !head_empty && (!out_valid || pop);
  assign run_last  = (slot == head.count - 2'd1);
  assign head_done = load && run_last;
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (load) begin
      result.out_byte       <= head.data[slot];
      result.out_run_last   <= run_last;
      result.out_string_end <= run_last && head.str_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      slot      <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        slot      <= run_last ? 2'd0 : slot + 2'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### hdl/url_percent_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_percent_decoder: streaming URL percent decoder
// Decodes '+' and whitelisted %XX escapes in a byte stream, one byte a beat.
// ----------------------------------------------------------------------------
// The decoder accepts one encoded character per beat on the input queue port
// and delivers decoded characters on the result queue port. Each input beat
// causes zero to three result beats: a '+' becomes a space, a '%' and two hex
// digits become the decoded byte when it is on the whitelist, and otherwise
// the '%' and the digits come out as typed. The last result beat of each input
// carries out_run_last, and the last result of a string also carries
// out_string_end. An input beat is taken in every cycle while the internal job
// queue (JOB_DEPTH entries) has room, so bytes that expand to one result flow
// at one beat per cycle while results are popped every cycle; the result side
// delivers one beat per cycle unless pop holds it back, so an input that
// expands into three results occupies the output side for longer and the job
// queue absorbs such bursts. Each result passes through the job queue and then
// into the output register after its input beat.
module url_percent_decoder #(
  parameter int JOB_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  upd_pkg::in_item_t  item,
  output logic               empty,
  input  logic               pop,
  output upd_pkg::out_item_t result
);
  import upd_pkg::*;

  logic job_valid;
  job_t job;
  job_t head;
  logic head_empty;
  logic head_done;
  logic accept;

  // Each input byte is classified in the cycle it is accepted.
  assign accept = push && !full;

  upd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .job_valid (job_valid),
    .job       (job)
  );

  // Jobs wait here so the front and the result side stall independently.
  upd_job_fifo #(
    .DEPTH (JOB_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (job_valid),
    .wr_job (job),
    .rd_en  (head_done),
    .head   (head),
    .full   (full),
    .empty  (head_empty)
  );

  // The back end emits one byte of the head job per cycle while its output register is empty or popped.
  upd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_empty (head_empty),
    .head_done  (head_done),
    .pop        (pop),
    .empty      (empty),
    .result     (result)
  );

endmodule
